// File: sv/imh_pkg.sv
package imh_pkg;

  localparam int unsigned Capacity   = 256;
  localparam int unsigned KeyCount   = 256;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned SlotW      = $clog2(Capacity);
  localparam int unsigned KeyW       = 8;
  localparam int unsigned CountW     = 9;

  typedef enum logic [1:0] {
    OpInsert = 2'd0,
    OpPop    = 2'd1,
    OpQuery  = 2'd2,
    OpNone   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2
  } status_e;

  // datapath micro-operations issued by the controller
  typedef enum logic [3:0] {
    CmdIdle,
    CmdLoad,      // latch op/key/value, read presence and position
    CmdAppend,    // write new entry at count, set presence
    CmdUpdRead,   // read entry at position
    CmdUpdWrite,  // write new value, pick direction
    CmdPopRead,   // read root and last entry
    CmdPopWrite,  // move last to root, clear presence
    CmdUpRead,    // read parent of cursor
    CmdUpSwap,    // swap cursor and parent
    CmdDnRead,    // read both children of cursor
    CmdDnSwap     // swap cursor with smaller child
  } cmd_e;

  typedef struct packed {
    logic    present;   // key present in heap
    logic    full;
    logic    empty;
    logic    up_go;     // parent larger than cursor
    logic    dn_go;     // child smaller than cursor
    logic    val_fell;  // updated value below old value
    logic    at_root;
    logic    last_one;  // pop takes the only entry
  } stat_t;

endpackage

// File: sv/imh_datapath.sv
module imh_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  imh_pkg::cmd_e                    cmd_i,
  input  logic [1:0]                       op_i,
  input  logic [imh_pkg::KeyW-1:0]         key_i,
  input  logic signed [imh_pkg::ValueWidth-1:0] value_i,
  output imh_pkg::stat_t                   stat_o,
  output logic [imh_pkg::KeyW-1:0]         popped_key_o,
  output logic [imh_pkg::CountW-1:0]       count_o,
  output logic                             present_o
);

  localparam int unsigned VW = imh_pkg::ValueWidth;
  localparam int unsigned SW = imh_pkg::SlotW;
  localparam int unsigned KW = imh_pkg::KeyW;
  localparam int unsigned CW = imh_pkg::CountW;

  // entry memory: key and biased value, one write port, reads registered
  logic [KW+VW-1:0] heap_mem [imh_pkg::Capacity];
  logic [SW-1:0]    pos_mem  [imh_pkg::KeyCount];
  logic [imh_pkg::KeyCount-1:0] pres_q;

  logic [CW-1:0] count_q;
  logic [KW-1:0] key_q;
  logic [VW-1:0] val_q;        // biased
  logic [SW-1:0] cur_q;        // cursor slot
  logic [KW+VW-1:0] cur_ent_q; // entry held at cursor
  logic [KW+VW-1:0] rd_a_q, rd_b_q;
  logic [SW-1:0] pos_q;
  logic [KW-1:0] popped_q;

  // displaced entry of a swap, written back in the following gap cycle
  logic [KW+VW-1:0] sw_ent_q;
  logic             sw_en_q;
  logic [SW-1:0]    sw_slot_q;

  logic [VW-1:0] val_bias;
  assign val_bias = value_i ^ {1'b1, {(VW-1){1'b0}}};

  logic [SW-1:0] parent, lchild, rchild;
  assign parent = SW'((cur_q - 1'b1) >> 1);
  assign lchild = {cur_q[SW-2:0], 1'b1};
  assign rchild = lchild + 1'b1;

  logic [CW:0] lc_ext, rc_ext;
  assign lc_ext = {1'b0, cur_q, 1'b1};
  assign rc_ext = lc_ext + 1'b1;

  logic [VW-1:0] cur_v, a_v, b_v;
  assign cur_v = cur_ent_q[VW-1:0];
  assign a_v   = rd_a_q[VW-1:0];
  assign b_v   = rd_b_q[VW-1:0];

  logic has_l, has_r, pick_r;
  assign has_l  = (CW+1)'(lc_ext) < {1'b0, count_q};
  assign has_r  = (CW+1)'(rc_ext) < {1'b0, count_q};
  assign pick_r = has_r && (b_v < a_v);

  logic [KW+VW-1:0] child_ent;
  logic [SW-1:0]    child_slot;
  assign child_ent  = pick_r ? rd_b_q : rd_a_q;
  assign child_slot = pick_r ? rchild : lchild;

  logic [SW-1:0] last_slot;
  assign last_slot = SW'(count_q - 1'b1);

  always_comb begin
    stat_o.present  = pres_q[key_q];
    stat_o.full     = count_q == CW'(imh_pkg::Capacity);
    stat_o.empty    = count_q == '0;
    stat_o.up_go    = (cur_q != '0) && (cur_v < a_v);
    stat_o.dn_go    = has_l && (child_ent[VW-1:0] < cur_v);
    stat_o.val_fell = val_q < a_v;
    stat_o.at_root  = cur_q == '0;
    stat_o.last_one = count_q == CW'(1);
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      imh_pkg::CmdIdle: begin
        // gap after a swap: the controller issues no read here
        if (sw_en_q) begin
          heap_mem[sw_slot_q] <= sw_ent_q;
          pos_mem[sw_ent_q[KW+VW-1:VW]] <= sw_slot_q;
        end
      end
      imh_pkg::CmdLoad: begin
        key_q <= key_i;
        val_q <= val_bias;
        pos_q <= pos_mem[key_i];
      end
      imh_pkg::CmdAppend: begin
        heap_mem[count_q[SW-1:0]] <= {key_q, val_q};
        pos_mem[key_q] <= count_q[SW-1:0];
        cur_q     <= count_q[SW-1:0];
        cur_ent_q <= {key_q, val_q};
      end
      imh_pkg::CmdUpdRead: begin
        rd_a_q <= heap_mem[pos_q];
        cur_q  <= pos_q;
      end
      imh_pkg::CmdUpdWrite: begin
        heap_mem[cur_q] <= {key_q, val_q};
        cur_ent_q <= {key_q, val_q};
      end
      imh_pkg::CmdPopRead: begin
        rd_a_q <= heap_mem[0];
        rd_b_q <= heap_mem[last_slot];
      end
      imh_pkg::CmdPopWrite: begin
        popped_q <= rd_a_q[KW+VW-1:VW];
        heap_mem[0] <= rd_b_q;
        pos_mem[rd_b_q[KW+VW-1:VW]] <= '0;
        cur_q     <= '0;
        cur_ent_q <= rd_b_q;
      end
      imh_pkg::CmdUpRead: rd_a_q <= heap_mem[parent];
      imh_pkg::CmdUpSwap: begin
        heap_mem[parent] <= cur_ent_q;
        pos_mem[cur_ent_q[KW+VW-1:VW]] <= parent;
        cur_q <= parent;
      end
      imh_pkg::CmdDnRead: begin
        rd_a_q <= heap_mem[lchild];
        rd_b_q <= heap_mem[rchild];
      end
      imh_pkg::CmdDnSwap: begin
        heap_mem[child_slot] <= cur_ent_q;
        pos_mem[cur_ent_q[KW+VW-1:VW]] <= child_slot;
        cur_q <= child_slot;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_en_q <= 1'b0;
    end else begin
      sw_en_q <= (cmd_i == imh_pkg::CmdUpSwap) || (cmd_i == imh_pkg::CmdDnSwap);
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i == imh_pkg::CmdUpSwap) begin
      sw_ent_q  <= rd_a_q;
      sw_slot_q <= cur_q;
    end else if (cmd_i == imh_pkg::CmdDnSwap) begin
      sw_ent_q  <= child_ent;
      sw_slot_q <= cur_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pres_q  <= '0;
      count_q <= '0;
    end else begin
      case (cmd_i)
        imh_pkg::CmdAppend: begin
          pres_q[key_q] <= 1'b1;
          count_q <= count_q + 1'b1;
        end
        imh_pkg::CmdPopWrite: begin
          pres_q[rd_a_q[KW+VW-1:VW]] <= 1'b0;
          count_q <= count_q - 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign popped_key_o = popped_q;
  assign count_o      = count_q;
  assign present_o    = (op_i == imh_pkg::OpQuery) && pres_q[key_q];

endmodule

// File: sv/imh_ctrl.sv
module imh_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          op_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic                pop_ok_o,
  output logic [1:0]          op_o,
  output imh_pkg::cmd_e       cmd_o,
  input  imh_pkg::stat_t      stat_i
);

  typedef enum logic [3:0] {
    SIdle, SDecide, SUpdRead, SUpdWrite, SPopRead, SPopWrite,
    SUpRead, SUpTest, SUpSwap, SDnRead, SDnTest, SDnSwap, SGap, SDone
  } state_e;

  state_e state_q;
  logic [1:0] op_q, status_q;
  logic pop_ok_q, up_q;

  assign in_ready_o  = state_q == SIdle;
  assign out_valid_o = state_q == SDone;
  assign status_o    = status_q;
  assign pop_ok_o    = pop_ok_q;
  assign op_o        = op_q;

  always_comb begin
    cmd_o = imh_pkg::CmdIdle;
    case (state_q)
      SIdle:     if (in_valid_i) cmd_o = imh_pkg::CmdLoad;
      SDecide:   if (op_q == imh_pkg::OpInsert && !stat_i.present && !stat_i.full)
                   cmd_o = imh_pkg::CmdAppend;
      SUpdRead:  cmd_o = imh_pkg::CmdUpdRead;
      SUpdWrite: cmd_o = imh_pkg::CmdUpdWrite;
      SPopRead:  cmd_o = imh_pkg::CmdPopRead;
      SPopWrite: cmd_o = imh_pkg::CmdPopWrite;
      SUpRead:   cmd_o = imh_pkg::CmdUpRead;
      SUpSwap:   cmd_o = imh_pkg::CmdUpSwap;
      SDnRead:   cmd_o = imh_pkg::CmdDnRead;
      SDnSwap:   cmd_o = imh_pkg::CmdDnSwap;
      default:   cmd_o = imh_pkg::CmdIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      op_q     <= imh_pkg::OpInsert;
      status_q <= imh_pkg::StOk;
      pop_ok_q <= 1'b0;
      up_q     <= 1'b0;
    end else begin
      case (state_q)
        SIdle: if (in_valid_i) begin
          op_q     <= op_i;
          status_q <= imh_pkg::StOk;
          pop_ok_q <= 1'b0;
          state_q  <= SDecide;
        end
        SDecide: begin
          case (op_q)
            imh_pkg::OpInsert: begin
              if (stat_i.present)   state_q <= SUpdRead;
              else if (stat_i.full) begin
                status_q <= imh_pkg::StFull;
                state_q  <= SDone;
              end else              state_q <= SUpRead;
            end
            imh_pkg::OpPop: begin
              if (stat_i.empty) begin
                status_q <= imh_pkg::StEmpty;
                state_q  <= SDone;
              end else begin
                pop_ok_q <= 1'b1;
                state_q  <= SPopRead;
              end
            end
            default: state_q <= SDone;
          endcase
        end
        SUpdRead:  state_q <= SUpdWrite;
        SUpdWrite: begin
          up_q    <= stat_i.val_fell;
          state_q <= stat_i.val_fell ? SUpRead : SDnRead;
        end
        SPopRead:  state_q <= SPopWrite;
        SPopWrite: state_q <= stat_i.last_one ? SDone : SDnRead;
        SUpRead:   state_q <= stat_i.at_root ? SDone : SUpTest;
        SUpTest:   state_q <= stat_i.up_go ? SUpSwap : SDone;
        SUpSwap:   begin
          up_q    <= 1'b1;
          state_q <= SGap;
        end
        SDnRead:   state_q <= SDnTest;
        SDnTest:   state_q <= stat_i.dn_go ? SDnSwap : SDone;
        SDnSwap:   begin
          up_q    <= 1'b0;
          state_q <= SGap;
        end
        SGap:      state_q <= up_q ? SUpRead : SDnRead;
        SDone:     if (out_ready_i) state_q <= SIdle;
        default:   state_q <= SIdle;
      endcase
    end
  end

endmodule

// File: sv/indexed_min_heap_top.sv
// indexed min-heap with decrease/increase-key, one result word per input word
// sequence: query, empty pop, insert into a full heap and unused op finish right
//   after the decide step; insert/update/pop sift the entry up to 8 levels of a
//   256-entry heap, each level read, tested, swapped, then a gap for write-back
// throughput: one word at a time, next word accepted the cycle after the result is taken
// reset: rst_ni asynchronous active low clears count, presence bits and
//   controller; entry and position memories stay undefined until written
module indexed_min_heap_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        op_i,
  input  logic [imh_pkg::KeyW-1:0]          key_i,
  input  logic signed [imh_pkg::ValueWidth-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        status_o,
  output logic [imh_pkg::KeyW-1:0]          popped_key_o,
  output logic                              present_o,
  output logic [imh_pkg::CountW-1:0]        count_o
);

  imh_pkg::cmd_e  cmd;
  imh_pkg::stat_t stat;
  logic pop_ok;
  logic [1:0] op_lat;
  logic [imh_pkg::KeyW-1:0] popped;

  // controller sequences the sift; datapath owns memories and compares
  imh_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i,
    .out_valid_o, .out_ready_i, .status_o, .pop_ok_o(pop_ok),
    .op_o(op_lat), .cmd_o(cmd), .stat_i(stat)
  );

  imh_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .op_i(op_lat), .key_i, .value_i,
    .stat_o(stat), .popped_key_o(popped), .count_o, .present_o
  );

  // popped key shown only on a successful pop
  assign popped_key_o = pop_ok ? popped : '0;

endmodule

// File: sv/imh_checker.sv
module imh_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] status_o,
  input logic [7:0] popped_key_o,
  input logic       present_o,
  input logic [8:0] count_o
);

  a_no_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(count_o))
    else $error("result dropped");

  a_empty_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != 2'd0 |-> popped_key_o == 8'd0 && !present_o)
    else $error("bad fields on error status");

  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_o <= 9'd256) else $error("count over capacity");

endmodule

bind indexed_min_heap_top imh_checker u_chk (.*);
